// ===== sv/pwlcs_pkg.sv =====
// Shared types and constants for the piecewise linear contrast stretch.
package pwlcs_pkg;

    localparam int unsigned PIX_W     = 8;
    localparam int unsigned NUM_W     = 2 * PIX_W;      // numerator N
    localparam int unsigned REM_W     = NUM_W + 1;      // 2N + D
    localparam int unsigned DSH_W     = 2 * PIX_W;      // 2D shifted to the top quotient bit
    localparam int unsigned DIV_CELLS = PIX_W;          // one quotient bit per cell
    localparam int unsigned FRONT_STAGES = 2;
    localparam int unsigned PIPE_DEPTH   = FRONT_STAGES + DIV_CELLS;
    localparam int unsigned CNT_W        = $clog2(PIPE_DEPTH + 1);

    localparam logic [PIX_W-1:0] LEVEL_MAX = 8'd255;

    // register indexes
    localparam logic [1:0] REG_IN_LOW   = 2'd0;
    localparam logic [1:0] REG_IN_HIGH  = 2'd1;
    localparam logic [1:0] REG_OUT_LOW  = 2'd2;
    localparam logic [1:0] REG_OUT_HIGH = 2'd3;

    localparam logic [PIX_W-1:0] RST_IN_LOW   = 8'd0;
    localparam logic [PIX_W-1:0] RST_IN_HIGH  = 8'd255;
    localparam logic [PIX_W-1:0] RST_OUT_LOW  = 8'd0;
    localparam logic [PIX_W-1:0] RST_OUT_HIGH = 8'd255;

    typedef struct packed {
        logic [PIX_W-1:0] in_low;
        logic [PIX_W-1:0] in_high;
        logic [PIX_W-1:0] out_low;
        logic [PIX_W-1:0] out_high;
    } t_cfg;

    // what one divider cell hands to the next
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DSH_W-1:0] dsh;
        logic [PIX_W-1:0] quo;
        logic             last;
    } t_cell;

endpackage

// ===== sv/pwlcs_front.sv =====
// Segment selection, products and rounding numerator ahead of the divider chain.
module pwlcs_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [7:0]             i_pixel,
    input  logic                   i_last,
    input  pwlcs_pkg::t_cfg        i_cfg,
    output logic                   o_valid,
    input  logic                   i_ready,
    output pwlcs_pkg::t_cell       o_data
);

    logic                       w_below;
    logic                       w_above;
    logic [pwlcs_pkg::PIX_W-1:0] w_den;
    logic [pwlcs_pkg::PIX_W-1:0] w_level;
    logic [pwlcs_pkg::PIX_W-1:0] w_slope;
    logic [pwlcs_pkg::PIX_W-1:0] w_off;
    logic                       w_neg;

    logic                       r_a_valid;
    logic [pwlcs_pkg::NUM_W-1:0] r_a_base;
    logic [pwlcs_pkg::NUM_W-1:0] r_a_prod;
    logic [pwlcs_pkg::PIX_W-1:0] r_a_den;
    logic                       r_a_neg;
    logic                       r_a_last;

    logic                       r_b_valid;
    pwlcs_pkg::t_cell           r_b_data;

    logic                       w_a_ready;
    logic                       w_b_ready;
    logic [pwlcs_pkg::NUM_W:0]   w_num_wide;
    logic [pwlcs_pkg::NUM_W-1:0] w_num;
    pwlcs_pkg::t_cell           n_b_data;

    assign w_below = i_pixel < i_cfg.in_low;
    assign w_above = i_pixel > i_cfg.in_high;

    always_comb begin
        w_neg = 1'b0;
        if (w_below) begin
            w_den   = i_cfg.in_low;
            w_level = '0;
            w_slope = i_cfg.out_low;
            w_off   = i_pixel;
        end else if (w_above) begin
            w_den   = pwlcs_pkg::LEVEL_MAX - i_cfg.in_high;
            w_level = i_cfg.out_high;
            w_slope = pwlcs_pkg::LEVEL_MAX - i_cfg.out_high;
            w_off   = i_pixel - i_cfg.in_high;
        end else if (i_cfg.in_high == i_cfg.in_low) begin
            // zero-width middle: out_low / 1
            w_den   = 8'd1;
            w_level = i_cfg.out_low;
            w_slope = '0;
            w_off   = '0;
        end else begin
            w_den   = i_cfg.in_high - i_cfg.in_low;
            w_level = i_cfg.out_low;
            w_off   = i_pixel - i_cfg.in_low;
            if (i_cfg.out_high >= i_cfg.out_low) begin
                w_slope = i_cfg.out_high - i_cfg.out_low;
            end else begin
                w_slope = i_cfg.out_low - i_cfg.out_high;
                w_neg   = 1'b1;
            end
        end
    end

    assign w_b_ready = !r_b_valid || i_ready;
    assign w_a_ready = !r_a_valid || w_b_ready;
    assign o_ready   = w_a_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_a_ready) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && w_a_ready) begin
            r_a_base <= 16'(w_level) * 16'(w_den);
            r_a_prod <= 16'(w_slope) * 16'(w_off);
            r_a_den  <= w_den;
            r_a_neg  <= w_neg;
            r_a_last <= i_last;
        end
    end

    // N never exceeds 255 * D, so the sum fits in NUM_W bits
    assign w_num_wide = r_a_neg ? ({1'b0, r_a_base} - {1'b0, r_a_prod})
                                : ({1'b0, r_a_base} + {1'b0, r_a_prod});
    assign w_num      = w_num_wide[pwlcs_pkg::NUM_W-1:0];

    always_comb begin
        n_b_data.rem  = {w_num, 1'b0} + pwlcs_pkg::REM_W'(r_a_den);
        n_b_data.dsh  = {r_a_den, 8'd0};
        n_b_data.quo  = '0;
        n_b_data.last = r_a_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_b_ready) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_a_valid && w_b_ready) begin
            r_b_data <= n_b_data;
        end
    end

    assign o_valid = r_b_valid;
    assign o_data  = r_b_data;

endmodule

// ===== sv/pwlcs_div_cell.sv =====
// One restoring-division cell: resolves one quotient bit and passes the rest on.
module pwlcs_div_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  pwlcs_pkg::t_cell i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output pwlcs_pkg::t_cell o_data
);

    logic             r_valid;
    pwlcs_pkg::t_cell r_data;
    pwlcs_pkg::t_cell n_data;
    logic             w_fits;
    logic             w_load;

    assign w_load  = !r_valid || i_ready;
    assign o_ready = w_load;

    assign w_fits = i_data.rem >= {1'b0, i_data.dsh};

    always_comb begin
        n_data.rem  = w_fits ? (i_data.rem - {1'b0, i_data.dsh}) : i_data.rem;
        n_data.dsh  = i_data.dsh >> 1;
        n_data.quo  = {i_data.quo[pwlcs_pkg::PIX_W-2:0], w_fits};
        n_data.last = i_data.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && w_load) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== sv/piecewise_linear_contrast_stretch.sv =====
// Top level: configuration registers, front end and the divider cell chain.
//
//  channel   | dir | handshake              | payload
//  s_axis    | in  | tvalid / tready         | tdata[7:0] pixel_in, tlast last_in
//  m_axis    | out | tvalid / tready         | tdata[7:0] pixel_out, tlast last_out
//  cfg       | in  | we (no back-pressure)   | index[1:0], data[7:0]
//
// One pixel per clock sustained while m_axis does not stall; 2 front stages + 8 divider cells,
// one quotient bit per cell.
// Every stage has its own valid bit and loads when empty or when its successor moves,
// so bubbles close up while the output is stalled; tready falls only when all ten are full.
// Synchronous active-low reset clears the valid bits and restores the register defaults.
module piecewise_linear_contrast_stretch (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] pixel_in
    input  logic       i_s_axis_tlast,
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] pixel_out
    output logic       o_m_axis_tlast,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    localparam int unsigned NCELL = pwlcs_pkg::DIV_CELLS;

    logic [7:0]       r_in_low;
    logic [7:0]       r_in_high;
    logic [7:0]       r_out_low;
    logic [7:0]       r_out_high;
    pwlcs_pkg::t_cfg  w_cfg;

    logic             c_valid [0:NCELL];
    logic             c_ready [0:NCELL];
    pwlcs_pkg::t_cell c_data  [0:NCELL];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_low   <= pwlcs_pkg::RST_IN_LOW;
            r_in_high  <= pwlcs_pkg::RST_IN_HIGH;
            r_out_low  <= pwlcs_pkg::RST_OUT_LOW;
            r_out_high <= pwlcs_pkg::RST_OUT_HIGH;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pwlcs_pkg::REG_IN_LOW:   r_in_low   <= i_cfg_data;
                pwlcs_pkg::REG_IN_HIGH:  r_in_high  <= i_cfg_data;
                pwlcs_pkg::REG_OUT_LOW:  r_out_low  <= i_cfg_data;
                pwlcs_pkg::REG_OUT_HIGH: r_out_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_cfg.in_low   = r_in_low;
        w_cfg.in_high  = r_in_high;
        w_cfg.out_low  = r_out_low;
        w_cfg.out_high = r_out_high;
    end

    pwlcs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_pixel (i_s_axis_tdata),
        .i_last  (i_s_axis_tlast),
        .i_cfg   (w_cfg),
        .o_valid (c_valid[0]),
        .i_ready (c_ready[0]),
        .o_data  (c_data[0])
    );

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        pwlcs_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[k]),
            .o_ready (c_ready[k]),
            .i_data  (c_data[k]),
            .o_valid (c_valid[k+1]),
            .i_ready (c_ready[k+1]),
            .o_data  (c_data[k+1])
        );
    end

    assign c_ready[NCELL]  = i_m_axis_tready;
    assign o_m_axis_tvalid = c_valid[NCELL];
    assign o_m_axis_tdata  = c_data[NCELL].quo;
    assign o_m_axis_tlast  = c_data[NCELL].last;

endmodule

// ===== sv/pwlcs_checker.sv =====
// Port-level checks for the contrast stretch, bound to the top level.
module pwlcs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_axis_tvalid,
    input logic       i_s_axis_tready,
    input logic       i_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] i_m_axis_tdata,
    input logic       i_m_axis_tlast
);

    logic                           w_in_beat;
    logic                           w_out_beat;
    logic [pwlcs_pkg::CNT_W-1:0]    r_pending;

    assign w_in_beat  = i_s_axis_tvalid && i_s_axis_tready;
    assign w_out_beat = i_m_axis_tvalid && i_m_axis_tready;

    // beats taken but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (w_in_beat && !w_out_beat) begin
            r_pending <= r_pending + 1'b1;
        end else if (w_out_beat && !w_in_beat) begin
            r_pending <= r_pending - 1'b1;
        end
    end

    a_no_phantom_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending == '0) |-> !i_m_axis_tvalid)
        else $error("output beat offered with nothing in flight");

    // every stage full and the output held: nothing can move
    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_pending == pwlcs_pkg::CNT_W'(pwlcs_pkg::PIPE_DEPTH)) && !i_m_axis_tready)
            |-> !i_s_axis_tready)
        else $error("input accepted with every stage full");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_axis_tvalid)
        else $error("output valid straight after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_axis_tvalid && !i_m_axis_tready) |=>
            (i_m_axis_tvalid && $stable(i_m_axis_tdata) && $stable(i_m_axis_tlast)))
        else $error("stalled output beat changed");

endmodule

bind piecewise_linear_contrast_stretch pwlcs_checker u_pwlcs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .i_s_axis_tready (o_s_axis_tready),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata),
    .i_m_axis_tlast  (o_m_axis_tlast)
);

// ===== bench/pwlcs_checker.sv =====
// Bench checker for the contrast stretch: tracks the curve, predicts and compares.
module pwlcs_tb_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  logic             i_s_tready,
    input  logic [7:0]       i_s_tdata,   // [7:0] pixel_in
    input  logic             i_s_tlast,
    input  logic             i_m_tvalid,
    input  logic             i_m_tready,
    input  logic [7:0]       i_m_tdata,   // [7:0] pixel_out
    input  logic             i_m_tlast,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [7:0]       i_cfg_data,
    output int unsigned      o_fail_count,
    output int unsigned      o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [pwlcs_pkg::PIX_W-1:0] level;
        logic                        last;
    } t_mapped;

    pwlcs_pkg::t_cfg curve;
    t_mapped         mapped_q[$];

    // Exact rational value of the segment, rounded half up.
    function automatic logic [pwlcs_pkg::PIX_W-1:0] stretch_level(
        input logic [pwlcs_pkg::PIX_W-1:0] pix
    );
        int unsigned z, lo_i, hi_i, lo_o, hi_o, num, den;
        z    = 32'(pix);
        lo_i = 32'(curve.in_low);
        hi_i = 32'(curve.in_high);
        lo_o = 32'(curve.out_low);
        hi_o = 32'(curve.out_high);
        if (z < lo_i) begin
            den = lo_i;
            num = lo_o * z;
        end else if (z > hi_i) begin
            den = 32'(pwlcs_pkg::LEVEL_MAX) - hi_i;
            num = hi_o * den + (32'(pwlcs_pkg::LEVEL_MAX) - hi_o) * (z - hi_i);
        end else begin
            den = hi_i - lo_i;
            if (den == 0)
                return curve.out_low;
            if (hi_o >= lo_o)
                num = lo_o * den + (hi_o - lo_o) * (z - lo_i);
            else
                num = lo_o * den - (lo_o - hi_o) * (z - lo_i);
        end
        return pwlcs_pkg::PIX_W'((2 * num + den) / (2 * den));
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("mismatch %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin : watch
        t_mapped want;
        if (!i_rst_n) begin
            curve = '{in_low: pwlcs_pkg::RST_IN_LOW, in_high: pwlcs_pkg::RST_IN_HIGH,
                      out_low: pwlcs_pkg::RST_OUT_LOW, out_high: pwlcs_pkg::RST_OUT_HIGH};
            mapped_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (mapped_q.size() == 0) begin
                    report_mismatch("unexpected pixel_out", 0, 32'(i_m_tdata));
                end else begin
                    want = mapped_q.pop_front();
                    if (i_m_tdata != want.level)
                        report_mismatch("pixel_out", 32'(want.level), 32'(i_m_tdata));
                    if (i_m_tlast != want.last)
                        report_mismatch("last_out", 32'(want.last), 32'(i_m_tlast));
                end
            end
            if (i_s_tvalid && i_s_tready)
                mapped_q.push_back('{level: stretch_level(i_s_tdata[pwlcs_pkg::PIX_W-1:0]),
                                     last: i_s_tlast});
            if (i_cfg_we) begin
                case (i_cfg_index)
                    pwlcs_pkg::REG_IN_LOW:   curve.in_low   = i_cfg_data;
                    pwlcs_pkg::REG_IN_HIGH:  curve.in_high  = i_cfg_data;
                    pwlcs_pkg::REG_OUT_LOW:  curve.out_low  = i_cfg_data;
                    pwlcs_pkg::REG_OUT_HIGH: curve.out_high = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending <= unsigned'(mapped_q.size());
    end

endmodule

// ===== bench/tb_top.sv =====
// Testbench top for the contrast stretch: clock, reset, stimulus, sink and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned GAP_MAX       = 16;
    localparam int unsigned QUIET_LIMIT   = 500;
    localparam int unsigned DRAIN_CYCLES  = pwlcs_pkg::PIPE_DEPTH + 4;
    localparam int unsigned RANDOM_PHASES = 12;
    localparam int unsigned PHASE_PIXELS  = 110;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       s_tvalid  = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata   = '0;
    logic       s_tlast   = 1'b0;
    logic       m_tvalid;
    logic       m_tready  = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       cfg_we    = 1'b0;
    logic [1:0] cfg_index = pwlcs_pkg::REG_IN_LOW;
    logic [7:0] cfg_data  = '0;

    int unsigned     fail_count;
    int unsigned     pending;
    int unsigned     quiet_cycles = 0;
    bit              no_idle = 1'b0;
    pwlcs_pkg::t_cfg cur_curve = '{in_low: pwlcs_pkg::RST_IN_LOW,
                                   in_high: pwlcs_pkg::RST_IN_HIGH,
                                   out_low: pwlcs_pkg::RST_OUT_LOW,
                                   out_high: pwlcs_pkg::RST_OUT_HIGH};

    always #5 clk = ~clk;

    piecewise_linear_contrast_stretch dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    pwlcs_tb_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic int unsigned draw_gap();
        if (no_idle)
            return 0;
        return $urandom_range(0, GAP_MAX);
    endfunction

    // Offer one beat after a random gap; returns at the edge that takes it.
    task automatic send_pixel(input logic [7:0] pix, input logic last);
        int unsigned gap;
        gap = draw_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
    endtask

    // Drain the pipe, then load all four breakpoint registers back to back.
    task automatic set_curve(input logic [7:0] il, input logic [7:0] ih,
                             input logic [7:0] ol, input logic [7:0] oh);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (pwlcs_pkg::PIPE_DEPTH) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= pwlcs_pkg::REG_IN_LOW;
        cfg_data  <= il;
        @(posedge clk);
        cfg_index <= pwlcs_pkg::REG_IN_HIGH;
        cfg_data  <= ih;
        @(posedge clk);
        cfg_index <= pwlcs_pkg::REG_OUT_LOW;
        cfg_data  <= ol;
        @(posedge clk);
        cfg_index <= pwlcs_pkg::REG_OUT_HIGH;
        cfg_data  <= oh;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_curve = '{in_low: il, in_high: ih, out_low: ol, out_high: oh};
    endtask

    // Mostly uniform, with a bias towards the breakpoints and the range ends.
    function automatic logic [7:0] pick_pixel();
        int v;
        case ($urandom_range(0, 7))
            0: v = int'(cur_curve.in_low) + int'($urandom_range(0, 2)) - 1;
            1: v = int'(cur_curve.in_high) + int'($urandom_range(0, 2)) - 1;
            2: v = int'($urandom_range(0, 1) * 255);
            default: v = int'($urandom_range(0, 255));
        endcase
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return 8'(v);
    endfunction

    // Sink: random stall before each beat.
    initial begin : sink
        int unsigned stall;
        do @(posedge clk); while (!rst_n);
        forever begin
            stall = draw_gap();
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles == QUIET_LIMIT) begin
                $display("status: fail");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin : stimulus
        logic [7:0] il, ih, ol, oh;
        logic       lst;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset curve is the identity
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b1);
        send_pixel(8'd128, 1'b0);

        set_curve(8'd64, 8'd192, 8'd32, 8'd224);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd63, 1'b0);
        send_pixel(8'd64, 1'b0);
        send_pixel(8'd128, 1'b0);
        send_pixel(8'd192, 1'b0);
        send_pixel(8'd193, 1'b0);
        send_pixel(8'd255, 1'b1);

        // zero-width middle segment
        set_curve(8'd100, 8'd100, 8'd50, 8'd200);
        send_pixel(8'd99, 1'b0);
        send_pixel(8'd100, 1'b0);
        send_pixel(8'd101, 1'b1);

        // in_high below in_low: middle never used
        set_curve(8'd200, 8'd50, 8'd10, 8'd240);
        send_pixel(8'd49, 1'b0);
        send_pixel(8'd50, 1'b0);
        send_pixel(8'd199, 1'b0);
        send_pixel(8'd200, 1'b0);
        send_pixel(8'd255, 1'b1);

        // falling middle segment
        set_curve(8'd50, 8'd200, 8'd220, 8'd30);
        send_pixel(8'd50, 1'b0);
        send_pixel(8'd125, 1'b0);
        send_pixel(8'd200, 1'b1);

        // narrowest outer segments
        set_curve(8'd1, 8'd254, 8'd128, 8'd128);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b1);

        for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: {il, ih, ol, oh} = {8'd0, 8'd0, 8'd0, 8'd0};
                1: {il, ih, ol, oh} = {8'd255, 8'd255, 8'd255, 8'd255};
                2: {il, ih, ol, oh} = {8'd0, 8'd255, 8'd255, 8'd0};
                3: {il, ih, ol, oh} = {8'd255, 8'd0, 8'd0, 8'd255};
                default: begin
                    ol = 8'($urandom_range(0, 255));
                    oh = 8'($urandom_range(0, 255));
                    case ($urandom_range(0, 4))
                        0: begin
                            il = 8'($urandom_range(0, 255));
                            ih = 8'($urandom_range(0, 255));
                        end
                        1: begin
                            il = 8'($urandom_range(0, 255));
                            ih = il;
                        end
                        2: begin
                            il = 8'($urandom_range(1, 255));
                            ih = 8'($urandom_range(0, il - 1));
                        end
                        3: begin
                            il = 8'($urandom_range(0, 254));
                            ih = 8'($urandom_range(il + 1, 255));
                            ol = 8'($urandom_range(1, 255));
                            oh = 8'($urandom_range(0, ol - 1));
                        end
                        default: begin
                            il = 8'($urandom_range(0, 255));
                            ih = 8'($urandom_range(il, 255));
                        end
                    endcase
                end
            endcase
            set_curve(il, ih, ol, oh);
            no_idle = (ph == 2) || ($urandom_range(0, 3) == 0);
            for (int unsigned n = 0; n < PHASE_PIXELS; n++) begin
                lst = (n == PHASE_PIXELS - 1) || ($urandom_range(0, 31) == 0);
                send_pixel(pick_pixel(), lst);
            end
            no_idle = 1'b0;
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
sv/pwlcs_pkg.sv
sv/pwlcs_front.sv
sv/pwlcs_div_cell.sv
sv/piecewise_linear_contrast_stretch.sv
sv/pwlcs_checker.sv
bench/pwlcs_checker.sv
bench/tb_top.sv
